### design/gyro_bias_cal_cursor_mapper_assert.svh
// Assertion macros shared by the cursor mapper modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef GYRO_BIAS_CAL_CURSOR_MAPPER_ASSERT_SVH
`define GYRO_BIAS_CAL_CURSOR_MAPPER_ASSERT_SVH

// same-cycle implication
`define GBCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbcm check failed");

// next-cycle implication
`define GBCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbcm check failed");

`endif

### design/gbcm_pkg.sv
// Types and constants of the gyro bias calibration cursor mapper.
// No dependencies; imported by every module of the block.
package gbcm_pkg;

  localparam logic [1:0] MODE_GYRO = 2'd1;
  localparam logic [1:0] MODE_TILT = 2'd2;

  localparam logic [2:0] REG_DISCARD_COUNT  = 3'd0;
  localparam logic [2:0] REG_GYRO_DEADZONE  = 3'd1;
  localparam logic [2:0] REG_GYRO_GAIN      = 3'd2;
  localparam logic [2:0] REG_GYRO_LIMIT     = 3'd3;
  localparam logic [2:0] REG_ACCEL_DEADZONE = 3'd4;
  localparam logic [2:0] REG_ACCEL_GAIN     = 3'd5;
  localparam logic [2:0] REG_ACCEL_LIMIT    = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DISCARD = 2'd1,
    PH_COLLECT = 2'd2,
    PH_READY   = 2'd3
  } cal_phase_t;

  typedef enum logic [1:0] {
    LK_ZERO = 2'd0,
    LK_GYRO = 2'd1,
    LK_TILT = 2'd2
  } lane_kind_t;

  typedef struct packed {
    logic [1:0]         op_mode;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              send_report;
    logic [1:0]        cal_phase_out;
  } out_item_t;

  typedef struct packed {
    lane_kind_t         kind;
    logic               neg;
    logic signed [15:0] raw;
  } lane_req_t;

  typedef struct packed {
    logic [11:0] gyro_deadzone;
    logic [9:0]  gyro_gain;
    logic [6:0]  gyro_limit;
    logic [14:0] accel_deadzone;
    logic [7:0]  accel_gain;
    logic [6:0]  accel_limit;
  } map_cfg_t;

endpackage

### design/gbcm_cal.sv
// Calibration sequencer: phase, sample count, bias sums and constant divider.
// Depends on gbcm_pkg and the assertion macro header.
`include "gyro_bias_cal_cursor_mapper_assert.svh"

module gbcm_cal import gbcm_pkg::*; #(
  parameter int COLLECT_SAMPLES = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [1:0]         mode,
  input  logic signed [15:0] gx,
  input  logic signed [15:0] gz,
  input  logic [7:0]         discard_count,
  output cal_phase_t         phase_after,
  output logic               map_ready,
  output logic signed [15:0] bias_pitch,
  output logic signed [15:0] bias_yaw
);

  localparam int CLOG_N = $clog2(COLLECT_SAMPLES);
  localparam int SUM_W  = 16 + CLOG_N;
  localparam int DIV_K  = SUM_W + CLOG_N;
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [63:0] DIV_M =
    ((64'd1 << DIV_K) + 64'(COLLECT_SAMPLES) - 64'd1) / 64'(COLLECT_SAMPLES);
  localparam logic [MUL_W-1:0] DIV_MUL = DIV_M[MUL_W-1:0];
  localparam logic [7:0] COLLECT_LAST = 8'(COLLECT_SAMPLES);

  cal_phase_t phase, phase_next;
  logic [7:0] count, count_next, count_inc;
  logic signed [SUM_W-1:0] sum_pitch, sum_yaw, sum_pitch_next, sum_yaw_next;
  logic signed [SUM_W-1:0] div_pitch, div_yaw;
  logic done, div_go;

  function automatic logic signed [15:0] div_const(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [15:0]       q;
    mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    prod = PROD_W'(mag) * PROD_W'(DIV_MUL);
    q    = prod[DIV_K+15:DIV_K];
    return s[SUM_W-1] ? -$signed(q) : $signed(q);
  endfunction

  assign count_inc = count + 8'd1;

  always_comb begin
    phase_next = phase;
    if (mode == MODE_GYRO) begin
      unique case (phase)
        PH_IDLE:    phase_next = PH_DISCARD;
        PH_DISCARD: if (count_inc >= discard_count) phase_next = PH_COLLECT;
        PH_COLLECT: if (count_inc >= COLLECT_LAST) phase_next = PH_READY;
        PH_READY:   phase_next = PH_READY;
        default:    phase_next = PH_IDLE;
      endcase
    end else begin
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    count_next     = count;
    sum_pitch_next = sum_pitch;
    sum_yaw_next   = sum_yaw;
    done           = 1'b0;
    if (mode == MODE_GYRO) begin
      unique case (phase)
        PH_IDLE: count_next = '0;
        PH_DISCARD: begin
          count_next = count_inc;
          if (count_inc >= discard_count) begin
            count_next     = '0;
            sum_pitch_next = '0;
            sum_yaw_next   = '0;
          end
        end
        PH_COLLECT: begin
          count_next     = count_inc;
          sum_pitch_next = sum_pitch + SUM_W'(gx);
          sum_yaw_next   = sum_yaw + SUM_W'(gz);
          done           = (count_inc >= COLLECT_LAST);
        end
        PH_READY: count_next = count;
        default:  count_next = '0;
      endcase
    end else begin
      count_next     = '0;
      sum_pitch_next = '0;
      sum_yaw_next   = '0;
    end
  end

  assign phase_after = phase_next;
  assign map_ready   = (mode == MODE_GYRO) && (phase == PH_READY);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      sum_pitch <= '0;
      sum_yaw   <= '0;
      div_go    <= 1'b0;
    end else begin
      div_go <= take && done;
      if (take) begin
        phase     <= phase_next;
        count     <= count_next;
        sum_pitch <= sum_pitch_next;
        sum_yaw   <= sum_yaw_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && done) begin
      div_pitch <= sum_pitch_next;
      div_yaw   <= sum_yaw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_pitch <= '0;
      bias_yaw   <= '0;
    end else if (div_go) begin
      bias_pitch <= div_const(div_pitch);
      bias_yaw   <= div_const(div_yaw);
    end
  end

  `GBCM_ASSERT_NOW(a_div_in_ready, div_go, phase == PH_READY)
  `GBCM_ASSERT_NOW(a_collect_bound, phase == PH_COLLECT, count < COLLECT_LAST)
  `GBCM_ASSERT_NEXT(a_off_clears, take && (mode != MODE_GYRO), phase == PH_IDLE && count == 8'd0)

endmodule

### design/gbcm_lane.sv
// One axis lane: bias correction, deadzone, gain and clamp over two stages.
// Depends on gbcm_pkg.
module gbcm_lane import gbcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  lane_req_t          req,
  input  logic signed [15:0] bias,
  input  map_cfg_t           cfg,
  output logic signed [7:0]  result
);

  logic signed [17:0] v;
  logic [17:0] absv;
  logic [15:0] mag, dz;
  logic pass;

  logic        pass1, tilt1, sign1;
  logic [15:0] mag1;
  logic [9:0]  gain;
  logic        pass2, tilt2, sign2;
  logic [25:0] prod2;
  logic [13:0] q, qc;
  logic [6:0]  lim;

  always_comb begin
    unique case (req.kind)
      LK_GYRO: v = {{2{bias[15]}}, bias} - {{2{req.raw[15]}}, req.raw};
      LK_TILT: v = req.neg ? -{{2{req.raw[15]}}, req.raw} : {{2{req.raw[15]}}, req.raw};
      default: v = '0;
    endcase
    absv = v[17] ? 18'(-v) : 18'(v);
    mag  = absv[15:0];
    dz   = (req.kind == LK_TILT) ? {1'b0, cfg.accel_deadzone} : {4'b0, cfg.gyro_deadzone};
    pass = (req.kind != LK_ZERO) && (mag >= dz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass1 <= 1'b0;
      pass2 <= 1'b0;
    end else if (en) begin
      pass1 <= pass;
      pass2 <= pass1;
    end
  end

  assign gain = tilt1 ? {2'b0, cfg.accel_gain} : cfg.gyro_gain;

  always_ff @(posedge clk) begin
    if (en) begin
      tilt1 <= (req.kind == LK_TILT);
      sign1 <= v[17];
      mag1  <= mag;
      tilt2 <= tilt1;
      sign2 <= sign1;
      prod2 <= 26'(mag1) * 26'(gain);
    end
  end

  always_comb begin
    q   = tilt2 ? {2'b0, prod2[25:14]} : prod2[25:12];
    lim = tilt2 ? cfg.accel_limit : cfg.gyro_limit;
    qc  = (q > {7'b0, lim}) ? {7'b0, lim} : q;
    if (!pass2) begin
      result = '0;
    end else if (sign2) begin
      result = -$signed({1'b0, qc[6:0]});
    end else begin
      result = $signed({1'b0, qc[6:0]});
    end
  end

endmodule

### design/gyro_bias_cal_cursor_mapper.sv
// Gyro bias calibration cursor mapper: one IMU sample in, one cursor beat out per cycle.
// A new sample is taken every cycle unless the output beat is held; each result
// passes in turn through the capture stage, the deadzone stage, the gain multiplier
// stage and the output register. The x and y axes run in two lanes side by side
// and merge into one output beat. Calibration bias is divided by a constant
// multiplier in the cycle after collection ends.
// Depends on gbcm_pkg, gbcm_cal, gbcm_lane and the assertion macro header.
`include "gyro_bias_cal_cursor_mapper_assert.svh"

module gyro_bias_cal_cursor_mapper import gbcm_pkg::*; #(
  parameter int COLLECT_SAMPLES = 50
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0] discard_count;
  map_cfg_t   cfg;

  logic take, adv;
  logic v0, v1, v2;
  cal_phase_t phase_after, ph0, ph1, ph2;
  logic map_ready;
  logic signed [15:0] bias_pitch, bias_yaw;
  lane_req_t req_x, req_y, req_x0, req_y0;
  logic signed [7:0] res_x, res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      discard_count      <= 8'd10;
      cfg.gyro_deadzone  <= 12'd24;
      cfg.gyro_gain      <= 10'd102;
      cfg.gyro_limit     <= 7'd127;
      cfg.accel_deadzone <= 15'd154;
      cfg.accel_gain     <= 8'd48;
      cfg.accel_limit    <= 7'd15;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DISCARD_COUNT:  discard_count      <= cfg_data[7:0];
        REG_GYRO_DEADZONE:  cfg.gyro_deadzone  <= cfg_data[11:0];
        REG_GYRO_GAIN:      cfg.gyro_gain      <= cfg_data[9:0];
        REG_GYRO_LIMIT:     cfg.gyro_limit     <= cfg_data[6:0];
        REG_ACCEL_DEADZONE: cfg.accel_deadzone <= cfg_data[14:0];
        REG_ACCEL_GAIN:     cfg.accel_gain     <= cfg_data[7:0];
        REG_ACCEL_LIMIT:    cfg.accel_limit    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && in_ready;

  gbcm_cal #(.COLLECT_SAMPLES(COLLECT_SAMPLES)) u_cal (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .mode          (in_data.op_mode),
    .gx            (in_data.gyro_x),
    .gz            (in_data.gyro_z),
    .discard_count (discard_count),
    .phase_after   (phase_after),
    .map_ready     (map_ready),
    .bias_pitch    (bias_pitch),
    .bias_yaw      (bias_yaw)
  );

  always_comb begin
    req_x = '{kind: LK_ZERO, neg: 1'b0, raw: '0};
    req_y = '{kind: LK_ZERO, neg: 1'b0, raw: '0};
    if (map_ready) begin
      req_x = '{kind: LK_GYRO, neg: 1'b1, raw: in_data.gyro_z};
      req_y = '{kind: LK_GYRO, neg: 1'b1, raw: in_data.gyro_x};
    end else if (in_data.op_mode == MODE_TILT) begin
      req_x = '{kind: LK_TILT, neg: 1'b1, raw: in_data.accel_x};
      req_y = '{kind: LK_TILT, neg: 1'b0, raw: in_data.accel_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= take;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_x0 <= req_x;
      req_y0 <= req_y;
      ph0    <= phase_after;
      ph1    <= ph0;
      ph2    <= ph1;
      out_data.move_x        <= res_x;
      out_data.move_y        <= res_y;
      out_data.send_report   <= (res_x != 8'sd0) || (res_y != 8'sd0);
      out_data.cal_phase_out <= ph2;
    end
  end

  gbcm_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .req    (req_x0),
    .bias   (bias_yaw),
    .cfg    (cfg),
    .result (res_x)
  );

  gbcm_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .req    (req_y0),
    .bias   (bias_pitch),
    .cfg    (cfg),
    .result (res_y)
  );

  `GBCM_ASSERT_NOW(a_stall_only_on_hold, !in_ready, out_valid && !out_ready)
  `GBCM_ASSERT_NEXT(a_take_enters_pipe, take, v0)
  `GBCM_ASSERT_NOW(a_quiet_while_cal,
    out_valid && (out_data.cal_phase_out == PH_DISCARD ||
                  out_data.cal_phase_out == PH_COLLECT),
    !out_data.send_report)

endmodule

### tb/gyro_bias_cal_cursor_mapper_tb.sv
// Self-checking testbench for the gyro bias calibration cursor mapper.
// Drives random IMU samples with gaps and stalls, predicts each cursor beat.
// Depends on gbcm_pkg and gyro_bias_cal_cursor_mapper.
module gyro_bias_cal_cursor_mapper_tb;
  import gbcm_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int COLLECT_N = 50;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned REG_MAX [7] = '{255, 4095, 1023, 127, 32767, 255, 127};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t sample_queue[$];
  out_item_t predicted_moves[$];
  int unsigned mismatch_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  logic hold_go = 1'b0;
  logic no_gaps = 1'b0;

  cal_phase_t cal_state;
  logic [7:0] cal_count;
  int pitch_sum, yaw_sum, pitch_bias, yaw_bias;
  logic [7:0] cfg_discard;
  logic [11:0] cfg_gyro_dz;
  logic [9:0] cfg_gyro_gain;
  logic [6:0] cfg_gyro_lim;
  logic [14:0] cfg_accel_dz;
  logic [7:0] cfg_accel_gain;
  logic [6:0] cfg_accel_lim;

  gyro_bias_cal_cursor_mapper #(.COLLECT_SAMPLES(COLLECT_N)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_calibration();
    cal_state = PH_IDLE;
    cal_count = '0;
    pitch_sum = 0;
    yaw_sum = 0;
    pitch_bias = 0;
    yaw_bias = 0;
  endfunction

  function automatic int scale_motion(int v, int unsigned dz, int unsigned gain,
                                      int unsigned sh, int unsigned lim);
    longint mag, q;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    if (mag < longint'(dz)) return 0;
    q = (mag * longint'(gain)) >>> sh;
    if (q > longint'(lim)) q = longint'(lim);
    return (v < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic out_item_t predict_cursor(in_item_t s);
    int dx, dy;
    out_item_t r;
    dx = 0;
    dy = 0;
    case (s.op_mode)
      MODE_GYRO: begin
        case (cal_state)
          PH_IDLE: begin
            cal_state = PH_DISCARD;
            cal_count = '0;
          end
          PH_DISCARD: begin
            cal_count = cal_count + 8'd1;
            if (cal_count >= cfg_discard) begin
              cal_state = PH_COLLECT;
              cal_count = '0;
              pitch_sum = 0;
              yaw_sum = 0;
            end
          end
          PH_COLLECT: begin
            pitch_sum += int'(s.gyro_x);
            yaw_sum += int'(s.gyro_z);
            cal_count = cal_count + 8'd1;
            if (cal_count >= COLLECT_N) begin
              pitch_bias = pitch_sum / COLLECT_N;
              yaw_bias = yaw_sum / COLLECT_N;
              cal_state = PH_READY;
            end
          end
          default: begin
            dx = scale_motion(-(int'(s.gyro_z) - yaw_bias), cfg_gyro_dz, cfg_gyro_gain,
                              12, cfg_gyro_lim);
            dy = scale_motion(-(int'(s.gyro_x) - pitch_bias), cfg_gyro_dz, cfg_gyro_gain,
                              12, cfg_gyro_lim);
          end
        endcase
      end
      MODE_TILT: begin
        clear_calibration();
        dx = scale_motion(-int'(s.accel_x), cfg_accel_dz, cfg_accel_gain, 14, cfg_accel_lim);
        dy = scale_motion(int'(s.accel_y), cfg_accel_dz, cfg_accel_gain, 14, cfg_accel_lim);
      end
      default: clear_calibration();
    endcase
    r.move_x = dx[7:0];
    r.move_y = dy[7:0];
    r.send_report = (dx != 0) || (dy != 0);
    r.cal_phase_out = cal_state;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatch_count < 50)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (predicted_moves.size() == 0) begin
      flag_mismatch("beat with nothing predicted, move_x", int'(got.move_x), 0);
      return;
    end
    want = predicted_moves.pop_front();
    if (got.move_x !== want.move_x)
      flag_mismatch("move_x", int'(got.move_x), int'(want.move_x));
    if (got.move_y !== want.move_y)
      flag_mismatch("move_y", int'(got.move_y), int'(want.move_y));
    if (got.send_report !== want.send_report)
      flag_mismatch("send_report", int'(got.send_report), int'(want.send_report));
    if (got.cal_phase_out !== want.cal_phase_out)
      flag_mismatch("cal_phase_out", int'(got.cal_phase_out), int'(want.cal_phase_out));
  endtask

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  // source: offer queued samples, predict on every accepted beat
  always @(posedge clk) begin : source
    int unsigned gap;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      gap = src_gap;
      if (in_valid && in_ready) begin
        predicted_moves.push_back(predict_cursor(in_data));
        gap = draw_gap();
      end
      if (!in_valid || in_ready) begin
        if (gap != 0) begin
          gap = gap - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      src_gap <= gap;
    end
  end

  // sink: take cursor beats with random stalls
  always @(posedge clk) begin : sink
    int unsigned gap;
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      gap = sink_gap;
      if (out_valid && out_ready) begin
        check_beat(out_data);
        gap = draw_gap();
      end else if (gap != 0) begin
        gap = gap - 1;
      end
      sink_gap <= gap;
      out_ready <= (gap == 0) && (hold_left == 0);
    end
  end

  // long hold-off of the sink, so that the block backs up
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_go)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_DISCARD_COUNT:  cfg_discard = value[7:0];
      REG_GYRO_DEADZONE:  cfg_gyro_dz = value[11:0];
      REG_GYRO_GAIN:      cfg_gyro_gain = value[9:0];
      REG_GYRO_LIMIT:     cfg_gyro_lim = value[6:0];
      REG_ACCEL_DEADZONE: cfg_accel_dz = value[14:0];
      REG_ACCEL_GAIN:     cfg_accel_gain = value[7:0];
      REG_ACCEL_LIMIT:    cfg_accel_lim = value[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic push_sample(logic [1:0] mode, logic signed [15:0] gx, logic signed [15:0] gz,
                             logic signed [15:0] ax, logic signed [15:0] ay);
    in_item_t s;
    s.op_mode = mode;
    s.gyro_x = gx;
    s.gyro_z = gz;
    s.accel_x = ax;
    s.accel_y = ay;
    sample_queue.push_back(s);
  endtask

  function automatic int pick_centre();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 200)) - 100;
  endfunction

  function automatic logic signed [15:0] rand_axis(int centre);
    int v;
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      default: begin
        v = centre + int'($urandom_range(0, 600)) - 300;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
      end
    endcase
  endfunction

  task automatic queue_gyro_run(int unsigned n);
    int cx, cz;
    cx = pick_centre();
    cz = pick_centre();
    repeat (n) push_sample(MODE_GYRO, rand_axis(cx), rand_axis(cz), 16'($urandom), 16'($urandom));
  endtask

  task automatic queue_session(int unsigned budget);
    int unsigned made, n;
    int cx, cy;
    made = 0;
    while (made < budget) begin
      case ((made == 0) ? 9 : $urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 8);
          cx = pick_centre();
          cy = pick_centre();
          repeat (n) push_sample(MODE_TILT, 16'($urandom), 16'($urandom),
                                 rand_axis(cx), rand_axis(cy));
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) push_sample(2'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
        end
        3: begin
          n = $urandom_range(1, cfg_discard + COLLECT_N + 10);
          queue_gyro_run(n);
        end
        default: begin
          n = cfg_discard + COLLECT_N + 2 + $urandom_range(0, 25);
          queue_gyro_run(n);
        end
      endcase
      made += n;
    end
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || predicted_moves.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_value(int unsigned max);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return max;
      2, 3: return $urandom_range(0, max / 16 + 1);
      default: return $urandom_range(0, max);
    endcase
  endfunction

  initial begin
    int unsigned vals [7];
    cfg_discard = 8'd10;
    cfg_gyro_dz = 12'd24;
    cfg_gyro_gain = 10'd102;
    cfg_gyro_lim = 7'd127;
    cfg_accel_dz = 15'd154;
    cfg_accel_gain = 8'd48;
    cfg_accel_lim = 7'd15;
    clear_calibration();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_sample(MODE_OFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_sample(MODE_SPARE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_sample(MODE_TILT, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF);
    push_sample(MODE_TILT, 16'shFFFF, 16'shFFFF, 16'sh7FFF, 16'sh8000);
    push_sample(MODE_TILT, 16'sh0000, 16'sh0000, -16'sd154, 16'sd154);
    push_sample(MODE_TILT, 16'sh0000, 16'sh0000, 16'sd153, -16'sd153);
    push_sample(MODE_TILT, 16'sh0000, 16'sh0000, -16'sd3000, 16'sd3000);
    push_sample(MODE_GYRO, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
    push_sample(MODE_GYRO, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
    push_sample(MODE_GYRO, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_sample(MODE_TILT, 16'sh0000, 16'sh0000, -16'sd20000, 16'sd0);
    push_sample(MODE_GYRO, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0000);
    push_sample(MODE_SPARE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_sample(MODE_OFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    for (int ph = 1; ph <= 10; ph++) begin
      wait_drained();
      no_gaps = (ph % 3 == 0) || (ph == 5);
      for (int i = REG_DISCARD_COUNT; i <= REG_ACCEL_LIMIT; i++) begin
        if (ph == 1)
          vals[i] = 0;
        else if (ph == 2)
          vals[i] = REG_MAX[i];
        else
          vals[i] = pick_value(REG_MAX[i]);
      end
      // keep the discard stretch short outside the all-max phase
      if (ph == 3)
        vals[REG_DISCARD_COUNT] = 12;
      else if (ph == 4)
        vals[REG_DISCARD_COUNT] = 2;
      else if (ph > 2 && vals[REG_DISCARD_COUNT] != 0)
        vals[REG_DISCARD_COUNT] = $urandom_range(0, 12);
      for (int i = REG_DISCARD_COUNT; i <= REG_ACCEL_LIMIT; i++)
        write_reg(CFG_INDEX_W'(i), vals[i]);
      queue_session(40);
      // leave calibration part way through discarding for the next phase
      if (ph == 3) begin
        push_sample(MODE_OFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_gyro_run(6);
      end
      if (ph == 5) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/gbcm_pkg.sv
design/gbcm_cal.sv
design/gbcm_lane.sv
design/gyro_bias_cal_cursor_mapper.sv
tb/gyro_bias_cal_cursor_mapper_tb.sv
